/* sv/nrt_pkg.sv */
// package: types, codes and constants of the node registry table
`default_nettype none
package nrt_pkg;
	localparam int NodeSlotsDefault  = 32;
	localparam int NonceLimitDefault = 64;

	typedef enum logic [2:0] {
		REQ_ADD_AUTO = 3'd0,
		REQ_ADD_AT   = 3'd1,
		REQ_RECORD   = 3'd2,
		REQ_REMOVE   = 3'd3,
		REQ_FIND     = 3'd4,
		REQ_READ     = 3'd5
	} req_code_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_PRESENT  = 3'd2,
		ST_RANGE    = 3'd3,
		ST_OCCUPIED = 3'd4,
		ST_NONE     = 3'd5
	} status_code_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [63:0] dev_id;
		logic [63:0] application_id;
		logic [31:0] nonce_value;
		logic [7:0]  slot_address;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  slot_out;
		logic [63:0] dev_id_out;
		logic [63:0] application_id_out;
		logic [31:0] last_nonce_out;
		logic [6:0]  nonce_count_out;
		logic        static_out;
		logic [8:0]  occupied_count;
	} rsp_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request, clear scan
		logic scan_step;  // compare current scan slot
		logic commit;     // decide, write, build result
	} nrt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} nrt_stat_t;
endpackage
`default_nettype wire

/* sv/node_registry_table.sv */
// top level of the node registry table
`default_nettype none
// One request is taken while busy is low; its result is shown with done high for one cycle
// after a scan of the id memory at one slot per cycle and a commit state. busy drops with
// done, so no new request is taken until the last result is shown. The result cannot be
// held off, so it must be taken when shown.
module node_registry_table #(
	parameter int NODE_SLOTS  = nrt_pkg::NodeSlotsDefault,
	parameter int NONCE_LIMIT = nrt_pkg::NonceLimitDefault
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  nrt_pkg::req_word_t   req,
	output logic                 done,
	output nrt_pkg::rsp_word_t   rsp
);
	import nrt_pkg::*;

	nrt_cmd_t  cmd;
	nrt_stat_t stat;

	nrt_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy));

	nrt_dp #(.NodeSlots(NODE_SLOTS), .NonceLimit(NONCE_LIMIT)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .stat(stat),
		.rsp(rsp), .rsp_valid(done));
endmodule
`default_nettype wire

/* sv/nrt_ram.sv */
// generic ram with one write port and one read port, registered read
`default_nettype none
module nrt_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] wa,
	input  wire logic [Width-1:0]         wd,
	input  wire logic [$clog2(Depth)-1:0] ra,
	output logic      [Width-1:0]         rd
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd <= mem_q[ra];
	end
endmodule
`default_nettype wire

/* sv/nrt_ctrl.sv */
// controller: sequences load, id scan and commit for each request
`default_nettype none
module nrt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  nrt_pkg::nrt_stat_t     stat,
	output nrt_pkg::nrt_cmd_t      cmd,
	output logic                   busy
);
	import nrt_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT} state_t;
	state_t state_q;

	always_comb begin
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.scan_step = (state_q == S_SCAN) || (state_q == S_DRAIN);
		cmd.commit    = (state_q == S_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy    <= 1'b1;
					end
				end
				S_SCAN: begin
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (stat.scan_last) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit) else $error("double commit");
	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !busy) else $error("busy after commit");
endmodule
`default_nettype wire

/* sv/nrt_dp.sv */
// datapath: slot store, id scan, update and result word
`default_nettype none
module nrt_dp #(
	parameter int NodeSlots  = nrt_pkg::NodeSlotsDefault,
	parameter int NonceLimit = nrt_pkg::NonceLimitDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  nrt_pkg::req_word_t     req,
	input  nrt_pkg::nrt_cmd_t      cmd,
	output nrt_pkg::nrt_stat_t     stat,
	output nrt_pkg::rsp_word_t     rsp,
	output logic                   rsp_valid
);
	import nrt_pkg::*;

	localparam int Aw = (NodeSlots > 1) ? $clog2(NodeSlots) : 1;
	localparam int Cw = $clog2(NodeSlots + 1);
	localparam logic [Cw:0] SlotsC = (Cw+1)'(NodeSlots);
	localparam logic [6:0] LimitC = 7'(NonceLimit);

	req_word_t req_q;
	logic [NodeSlots-1:0] used_q, static_q;
	logic [6:0] cnt_q [NodeSlots];
	logic [8:0] total_q;
	logic [Cw:0] ridx_q;   // address sent to id ram
	logic [Cw:0] cidx_q;   // slot whose id is on rd
	logic        cval_q;
	logic        hit_q;
	logic [Aw-1:0] hit_slot_q;
	logic        free_q;
	logic [Aw-1:0] free_slot_q;

	// result word pieces held from commit
	logic [2:0]  status_q;
	logic [7:0]  slot_q;
	logic [6:0]  cnt_o_q;
	logic        static_o_q;
	logic [8:0]  occ_q;
	logic        rep_q, fill_q, nonce_new_q;

	logic we;
	logic [Aw-1:0] wa, ra;
	logic [63:0] id_rd, app_rd;
	logic [31:0] nonce_rd;
	logic [63:0] id_wd, app_wd;
	logic [31:0] nonce_wd;
	logic nonce_we;

	assign stat.scan_last = (ridx_q == SlotsC);

	// during commit the read address points at the target slot
	logic [Aw-1:0] tgt;
	logic          addr_ok;
	assign addr_ok = ({1'b0, req_q.slot_address} < 9'(NodeSlots));
	assign ra = cmd.commit ? tgt : ridx_q[Aw-1:0];

	nrt_ram #(.Width(64), .Depth(NodeSlots)) u_id (
		.clk(clk), .we(we), .wa(wa), .wd(id_wd), .ra(ra), .rd(id_rd));
	nrt_ram #(.Width(64), .Depth(NodeSlots)) u_app (
		.clk(clk), .we(we), .wa(wa), .wd(app_wd), .ra(ra), .rd(app_rd));
	nrt_ram #(.Width(32), .Depth(NodeSlots)) u_nonce (
		.clk(clk), .we(nonce_we), .wa(wa), .wd(nonce_wd), .ra(ra), .rd(nonce_rd));

	// decision
	status_code_t st;
	logic do_fill, do_bump, do_rm, do_rep, fill_static;
	logic [7:0] slot_o;
	logic [6:0] cnt_new, cnt_cur;
	logic       occ_tgt;

	always_comb begin
		st = ST_NONE; do_fill = 1'b0; do_bump = 1'b0; do_rm = 1'b0; do_rep = 1'b0;
		fill_static = 1'b0; tgt = '0; slot_o = 8'd0;
		occ_tgt = used_q[req_q.slot_address[Aw-1:0]];
		unique case (req_q.req_type)
			REQ_ADD_AUTO: begin
				tgt = free_slot_q;
				if ({1'b0, total_q} >= 10'(NodeSlots)) st = ST_FULL;
				else if (hit_q) st = ST_PRESENT;
				else if (!free_q) st = ST_FULL;
				else begin st = ST_OK; do_fill = 1'b1; do_rep = 1'b1; end
			end
			REQ_ADD_AT: begin
				tgt = req_q.slot_address[Aw-1:0];
				slot_o = req_q.slot_address;
				if ({1'b0, total_q} >= 10'(NodeSlots)) st = ST_FULL;
				else if (hit_q) st = ST_PRESENT;
				else if (!addr_ok) st = ST_RANGE;
				else if (occ_tgt) st = ST_OCCUPIED;
				else begin st = ST_OK; do_fill = 1'b1; do_rep = 1'b1; fill_static = 1'b1; end
			end
			REQ_RECORD: begin
				tgt = hit_slot_q;
				if (hit_q) begin st = ST_OK; do_bump = 1'b1; do_rep = 1'b1; end
			end
			REQ_REMOVE: begin
				tgt = req_q.slot_address[Aw-1:0];
				slot_o = req_q.slot_address;
				if (!addr_ok) st = ST_RANGE;
				else if (occ_tgt) begin st = ST_OK; do_rm = 1'b1; end
			end
			REQ_FIND: begin
				tgt = hit_slot_q;
				if (hit_q) begin st = ST_OK; do_rep = 1'b1; end
			end
			REQ_READ: begin
				tgt = req_q.slot_address[Aw-1:0];
				slot_o = req_q.slot_address;
				if (!addr_ok) st = ST_RANGE;
				else if (occ_tgt) begin st = ST_OK; do_rep = 1'b1; end
			end
			default: ;
		endcase
		if (do_rep) slot_o = 8'(tgt);
		cnt_cur = cnt_q[tgt];
		cnt_new = (cnt_cur >= LimitC) ? 7'd1 : cnt_cur + 7'd1;
		if (fill_static) cnt_new = 7'd1;
	end

	assign we       = cmd.commit && do_fill;
	assign nonce_we = cmd.commit && (do_fill || do_bump);
	assign wa       = tgt;
	assign id_wd    = req_q.dev_id;
	assign app_wd   = req_q.application_id;
	assign nonce_wd = req_q.nonce_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			static_q  <= '0;
			total_q   <= '0;
			rsp_valid <= 1'b0;
			for (int i = 0; i < NodeSlots; i++) cnt_q[i] <= 7'd0;
		end else begin
			rsp_valid <= cmd.commit;
			if (cmd.commit) begin
				if (do_fill) begin
					used_q[tgt]   <= 1'b1;
					static_q[tgt] <= fill_static;
					cnt_q[tgt]    <= cnt_new;
					total_q       <= total_q + 9'd1;
				end
				if (do_bump) cnt_q[tgt] <= cnt_new;
				if (do_rm) begin
					used_q[tgt] <= 1'b0;
					cnt_q[tgt]  <= 7'd0;
					if (total_q != 9'd0) total_q <= total_q - 9'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req;
			ridx_q <= '0;
			cval_q <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			hit_slot_q  <= '0;
			free_slot_q <= '0;
		end else if (cmd.scan_step) begin
			if (ridx_q != SlotsC) ridx_q <= ridx_q + 1'b1;
			cidx_q <= ridx_q;
			cval_q <= (ridx_q != SlotsC);
			if (cval_q) begin
				if (!hit_q && used_q[cidx_q[Aw-1:0]] && id_rd == req_q.dev_id) begin
					hit_q <= 1'b1; hit_slot_q <= cidx_q[Aw-1:0];
				end
				if (!free_q && !used_q[cidx_q[Aw-1:0]]) begin
					free_q <= 1'b1; free_slot_q <= cidx_q[Aw-1:0];
				end
			end
		end
		if (cmd.commit) begin
			status_q    <= st;
			slot_q      <= slot_o;
			cnt_o_q     <= do_rep ? ((do_fill || do_bump) ? cnt_new : cnt_cur) : 7'd0;
			static_o_q  <= do_rep ? (do_fill ? fill_static : static_q[tgt]) : 1'b0;
			occ_q       <= total_q + {8'd0, do_fill} - {8'd0, do_rm && total_q != 0};
			rep_q       <= do_rep;
			fill_q      <= do_fill;
			nonce_new_q <= do_fill || do_bump;
		end
	end

	// stored fields of an unchanged slot come from the ram read made during commit
	always_comb begin
		rsp.status             = status_q;
		rsp.slot_out           = slot_q;
		rsp.dev_id_out         = !rep_q ? '0 : (fill_q ? req_q.dev_id : id_rd);
		rsp.application_id_out = !rep_q ? '0 : (fill_q ? req_q.application_id : app_rd);
		rsp.last_nonce_out     = !rep_q ? '0 : (nonce_new_q ? req_q.nonce_value : nonce_rd);
		rsp.nonce_count_out    = cnt_o_q;
		rsp.static_out         = static_o_q;
		rsp.occupied_count     = occ_q;
	end
endmodule
`default_nettype wire
